// File: hw/rtl/double_ended_queue_core_assert.svh
// Assertion macros shared by the deque checker.
// Each macro wraps one clocked implication that is disabled while reset is low.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define DEQ_ASSERT_IMP(lbl, a_clk, a_rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DEQ_ASSERT_NXT(lbl, a_clk, a_rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/deq_pkg.sv
// Package for the double-ended queue core: widths, operation and status codes,
// controller state type and the command and status bundles. No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

  // Fixed field widths and the default queue depth.
  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 5;

  // Operation codes carried by an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } deq_op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } deq_status_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } deq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // an input beat is accepted this cycle
    logic load;  // move the finished result into the output register
  } deq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register is empty or being drained this cycle
  } deq_stat_t;

endpackage

// File: hw/rtl/deq_in_if.sv
// Input channel of the deque core: valid/ready handshake with op and push word.
// Depends on deq_pkg for the field widths.
`timescale 1ns / 1ps

interface deq_in_if;
  logic                             valid;
  logic                             ready;
  logic [deq_pkg::OP_W-1:0]         op;
  logic signed [deq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

// File: hw/rtl/deq_out_if.sv
// Result channel of the deque core: valid/ready handshake with status, popped
// word and occupancy. Depends on deq_pkg for the field widths.
`timescale 1ns / 1ps

interface deq_out_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::STAT_W-1:0]        status;
  logic signed [deq_pkg::DATA_W-1:0] popped_value;
  logic [deq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output popped_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input occupancy,
                  output ready);
endinterface

// File: hw/rtl/deq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/deq_ctrl.sv
// Controller of the deque core: accepts one input beat at a time and hands the
// result to the output register once the slot read has completed. Uses deq_pkg.
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_cmd_t  cmd
);

  deq_pkg::deq_state_t state_r;
  deq_pkg::deq_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: an accepted beat moves to FETCH for the slot read, then waits
  // there until the output register can take its result.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = deq_pkg::ST_FETCH;
        end
      end
      deq_pkg::ST_FETCH: begin
        if (stat.out_free) begin
          state_nxt = deq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = deq_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      deq_pkg::ST_FETCH: begin
        cmd.load = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/deq_dp.sv
// Datapath of the deque core: head pointer, word count, slot RAM, pending
// result and output register. Uses deq_pkg and deq_ram.
`timescale 1ns / 1ps

module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  deq_pkg::deq_cmd_t                 cmd,
  output deq_pkg::deq_stat_t                stat,
  input  logic [deq_pkg::OP_W-1:0]          in_op,
  input  logic signed [deq_pkg::DATA_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [deq_pkg::STAT_W-1:0]        out_status,
  output logic signed [deq_pkg::DATA_W-1:0] out_popped_value,
  output logic [deq_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [AW-1:0] head_r;
  logic [AW-1:0] head_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  deq_pkg::deq_status_t pend_status_r;
  deq_pkg::deq_status_t pend_status_nxt;
  logic                 pend_pop_r;
  logic                 pend_pop_nxt;

  logic                              out_valid_r;
  deq_pkg::deq_status_t              out_status_r;
  logic [deq_pkg::DATA_W-1:0]        out_popped_r;
  logic [CW-1:0]                     out_occ_r;

  logic                       full;
  logic                       empty;
  logic [AW-1:0]              head_dec;
  logic [AW-1:0]              head_inc;
  logic [SW-1:0]              rear_sum;
  logic [SW-1:0]              rear_sum_m1;
  logic [AW-1:0]              rear_push;
  logic [AW-1:0]              rear_pop;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [deq_pkg::DATA_W-1:0] ram_rdata;

  // Slot positions, each wrapped modulo the depth with one compare.
  assign full        = (count_r == CW'(DEPTH));
  assign empty       = (count_r == '0);
  assign head_dec    = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc    = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign rear_sum    = SW'(head_r) + SW'(count_r);
  assign rear_sum_m1 = rear_sum - 1'b1;
  assign rear_push   = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);
  assign rear_pop    = (rear_sum_m1 >= SW'(DEPTH)) ? AW'(rear_sum_m1 - SW'(DEPTH))
                                                   : AW'(rear_sum_m1);

  // Decode the accepted beat: pointer update, slot access and pending result.
  always_comb begin
    head_nxt        = head_r;
    count_nxt       = count_r;
    pend_status_nxt = deq_pkg::STAT_OK;
    pend_pop_nxt    = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = head_dec;
    ram_re          = 1'b0;
    ram_raddr       = head_r;
    unique case (deq_pkg::deq_op_t'(in_op))
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          pend_status_nxt = deq_pkg::STAT_FULL;
        end else begin
          ram_we    = cmd.take;
          ram_waddr = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          pend_status_nxt = deq_pkg::STAT_FULL;
        end else begin
          ram_we    = cmd.take;
          ram_waddr = rear_push;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          pend_status_nxt = deq_pkg::STAT_EMPTY;
        end else begin
          ram_re       = cmd.take;
          ram_raddr    = head_r;
          pend_pop_nxt = 1'b1;
          head_nxt     = head_inc;
          count_nxt    = count_r - 1'b1;
        end
      end
      deq_pkg::OP_POP_REAR: begin
        if (empty) begin
          pend_status_nxt = deq_pkg::STAT_EMPTY;
        end else begin
          ram_re       = cmd.take;
          ram_raddr    = rear_pop;
          pend_pop_nxt = 1'b1;
          count_nxt    = count_r - 1'b1;
        end
      end
      default: begin
        pend_status_nxt = deq_pkg::STAT_OK;
      end
    endcase
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.take) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Pending result, held while the slot read completes.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_status_r <= pend_status_nxt;
      pend_pop_r    <= pend_pop_nxt;
    end
  end

  // Slot storage.
  deq_ram #(
    .WIDTH(deq_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_deq_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_push_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload; the occupancy is the count left by this beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= pend_status_r;
      out_popped_r <= pend_pop_r ? ram_rdata : '0;
      out_occ_r    <= count_r;
    end
  end

  assign stat.out_free    = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = $signed(out_popped_r);
  assign out_occupancy    = deq_pkg::OCC_W'(out_occ_r);

endmodule

// File: hw/rtl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue core.
// Depends on deq_pkg, deq_in_if, deq_out_if, deq_ctrl and deq_dp.
`timescale 1ns / 1ps

// Usage
// in_ch carries one operation per beat: push front, push rear, pop front or
// pop rear, plus the word to push. out_ch returns exactly one beat per input
// beat with the status (ok, full, empty), the popped word (zero unless a pop
// succeeded) and the number of words held afterwards.
// Sequencing: an accepted beat goes to the FETCH state for the registered
// read of the slot RAM, and its result then moves into the output register
// when that register is free; no new beat is taken before then.
// in_ch.ready rises again once the result has moved into the output register,
// so the next beat can be taken while that result still waits on out_ch.
// Reset: synchronous, active low; the queue comes up empty with the head at
// slot zero. The slot RAM is not cleared and needs no clearing pass.
// Stall: while out_ch.ready stays low the result holds steady; one further
// beat may be accepted and then in_ch.ready stays low until the stall ends.

module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;

  // Sequencing of accepted beats.
  deq_ctrl u_deq_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Pointers, slot storage and output register.
  deq_dp #(
    .DEPTH(DEPTH)
  ) u_deq_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_ch.op),
    .in_push_value   (in_ch.push_value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_popped_value(out_ch.popped_value),
    .out_occupancy   (out_ch.occupancy)
  );

endmodule

// File: hw/rtl/deq_checker.sv
// Port-level checker for the deque core, bound to double_ended_queue_core.
// Depends on deq_pkg and double_ended_queue_core_assert.svh.
`timescale 1ns / 1ps
`include "double_ended_queue_core_assert.svh"

module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [deq_pkg::STAT_W-1:0]        out_status,
  input logic signed [deq_pkg::DATA_W-1:0] out_popped_value,
  input logic [deq_pkg::OCC_W-1:0]         out_occupancy
);

  // A result beat waits until it is taken.
  `DEQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped")

  // Only one operation is in the slot read at a time: in_ready is low in the cycle after a beat is accepted.
  `DEQ_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second beat accepted too early")

  // A refused operation never returns a word.
  `DEQ_ASSERT_IMP(a_refused_zero, clk, rst_n, out_valid && (out_status != deq_pkg::STAT_OK), out_popped_value == '0, "refused operation returned a word")

  // Occupancy never exceeds the capacity.
  `DEQ_ASSERT_IMP(a_occ_bound, clk, rst_n, out_valid, 32'(out_occupancy) <= DEPTH, "occupancy above capacity")

endmodule

bind double_ended_queue_core deq_checker #(
  .DEPTH(DEPTH)
) u_deq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_popped_value(out_ch.popped_value),
  .out_occupancy   (out_ch.occupancy)
);

// File: tb/double_ended_queue_core_test.sv
// Self-checking testbench for double_ended_queue_core: a table of directed beats,
// then ~750 random beats, checked against typed-in results or an in-bench predictor.
// Depends on deq_pkg, deq_in_if, deq_out_if and the core itself.
`timescale 1ns / 1ps

module double_ended_queue_core_test;
  import deq_pkg::*;

  // One result beat as the core should send it.
  typedef struct packed {
    deq_status_t             status;
    logic signed [DATA_W-1:0] popped;
    logic [OCC_W-1:0]         occupancy;
  } deq_result_t;

  // One row of the directed table; has_want marks rows whose result is typed in.
  typedef struct packed {
    deq_op_t                  op;
    logic signed [DATA_W-1:0] word;
    bit                       has_want;
    deq_result_t              want;
  } deq_row_t;

  localparam int NUM_RANDOM   = 750;
  localparam int STALL_LIMIT  = 2000;
  localparam int BACKLOG_LEN  = 60;
  localparam int BACKLOG_AT   = 400;

  logic clk;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the deque contents.
  logic signed [DATA_W-1:0] shadow_slots [DEPTH_DEF];
  int                       front_pos;
  int                       word_count;

  deq_result_t expected_results [$];
  int          mismatches;
  int          beats_taken;
  int          idle_cycles;
  bit          backlog_done;

  // Directed beats: empty pops, extreme words, a wrap-around fill to full,
  // refused pushes, and a rear pop from the full queue.
  deq_row_t directed_rows [25] = '{
    '{OP_POP_FRONT,  32'sh0000_0000, 1'b1, '{STAT_EMPTY, 32'sh0000_0000, 5'd0}},
    '{OP_POP_REAR,   32'sh5a5a_5a5a, 1'b1, '{STAT_EMPTY, 32'sh0000_0000, 5'd0}},
    '{OP_PUSH_FRONT, 32'sh7fff_ffff, 1'b1, '{STAT_OK,    32'sh0000_0000, 5'd1}},
    '{OP_PUSH_REAR,  32'sh8000_0000, 1'b1, '{STAT_OK,    32'sh0000_0000, 5'd2}},
    '{OP_POP_FRONT,  32'shffff_ffff, 1'b1, '{STAT_OK,    32'sh7fff_ffff, 5'd1}},
    '{OP_POP_REAR,   32'sh0000_0000, 1'b1, '{STAT_OK,    32'sh8000_0000, 5'd0}},
    '{OP_PUSH_FRONT, 32'shffff_ffff, 1'b0, '0},
    '{OP_PUSH_REAR,  32'sh0000_0000, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'sh1234_5678, 1'b0, '0},
    '{OP_PUSH_REAR,  32'shedcb_a987, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'sh5555_5555, 1'b0, '0},
    '{OP_PUSH_REAR,  32'shaaaa_aaaa, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'sh0000_0001, 1'b0, '0},
    '{OP_PUSH_REAR,  32'sh8000_0001, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'sh7fff_fffe, 1'b0, '0},
    '{OP_PUSH_REAR,  32'sh0f0f_0f0f, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'shf0f0_f0f0, 1'b0, '0},
    '{OP_PUSH_REAR,  32'sh3333_cccc, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'shcccc_3333, 1'b0, '0},
    '{OP_PUSH_REAR,  32'sh00ff_00ff, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'shff00_ff00, 1'b0, '0},
    '{OP_PUSH_REAR,  32'sh1357_9bdf, 1'b0, '0},
    '{OP_PUSH_REAR,  32'sh2468_ace0, 1'b1, '{STAT_FULL,  32'sh0000_0000, 5'd16}},
    '{OP_PUSH_FRONT, 32'shdead_beef, 1'b1, '{STAT_FULL,  32'sh0000_0000, 5'd16}},
    '{OP_POP_REAR,   32'sh0000_0000, 1'b0, '0}
  };

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Middle stretch of the run in which neither side idles.
  function automatic bit quiet_stretch();
    return beats_taken >= 150 && beats_taken < 300;
  endfunction

  // Applies one operation to the shadow deque and returns the result it gives.
  function automatic deq_result_t deque_step(input deq_op_t op,
                                             input logic signed [DATA_W-1:0] word);
    deq_result_t r;
    r.status = STAT_OK;
    r.popped = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (word_count >= DEPTH_DEF) begin
          r.status = STAT_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          front_pos = (front_pos + DEPTH_DEF - 1) % DEPTH_DEF;
          shadow_slots[front_pos] = word;
          word_count++;
        end else begin
          shadow_slots[(front_pos + word_count) % DEPTH_DEF] = word;
          word_count++;
        end
      end
      OP_POP_FRONT: begin
        if (word_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = shadow_slots[front_pos];
          front_pos = (front_pos + 1) % DEPTH_DEF;
          word_count--;
        end
      end
      default: begin
        if (word_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = shadow_slots[(front_pos + word_count - 1) % DEPTH_DEF];
          word_count--;
        end
      end
    endcase
    r.occupancy = OCC_W'(word_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Offers one beat from a falling edge, waits for the handshake, records the
  // expected result and returns at the next falling edge.
  task automatic send_beat(input deq_op_t op, input logic signed [DATA_W-1:0] word,
                           input bit has_want, input deq_result_t want);
    deq_result_t predicted;
    while (!quiet_stretch() && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.push_value <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = deque_step(op, word);
    expected_results.push_back(has_want ? want : predicted);
    beats_taken++;
    @(negedge clk);
  endtask

  // Receiver: random back-pressure, plus one long hold-off so the core stalls its input.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!backlog_done && beats_taken >= BACKLOG_AT) begin
        backlog_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (BACKLOG_LEN) @(negedge clk);
      end else begin
        out_ch.ready <= quiet_stretch() || $urandom_range(99) >= 17;
      end
    end
  end

  // Result checker: each result beat against the oldest expectation.
  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
        if (out_ch.popped_value !== want.popped)
          report_mismatch($sformatf("popped_value %0d, expected %0d",
                                    out_ch.popped_value, want.popped));
        if (out_ch.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d",
                                    out_ch.occupancy, want.occupancy));
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, biased random runs, drain, verdict.
  initial begin
    int      sent;
    int      push_pct;
    int      run_len;
    deq_op_t op;

    mismatches       = 0;
    beats_taken      = 0;
    idle_cycles      = 0;
    backlog_done     = 1'b0;
    front_pos        = 0;
    word_count       = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_PUSH_FRONT;
    in_ch.push_value = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].word,
                directed_rows[i].has_want, directed_rows[i].want);

    // Runs that lean toward pushing, popping or neither, so the queue swings
    // between full and empty and both ends wrap many times.
    sent = 0;
    while (sent < NUM_RANDOM) begin
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      run_len = $urandom_range(10, 50);
      repeat (run_len) begin
        if ($urandom_range(99) < push_pct)
          op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        else
          op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
        send_beat(op, $urandom, 1'b0, '0);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
